// ===== src/vtct_pkg.sv =====
// ----------------------------------------------------------------------------
// vtct_pkg
// Shared types, constants and sequence tables of the VT100 character
// translator: command format between front and back, escape texts.
// ----------------------------------------------------------------------------
package vtct_pkg;

    localparam int CMDQ_DEPTH_DEF = 2;

    localparam logic [7:0] ESC_BYTE = 8'd27;
    localparam logic [7:0] LF_BYTE  = 8'd10;
    localparam logic [7:0] CR_BYTE  = 8'd13;
    localparam logic [7:0] REV_ON_BYTE  = 8'h52;
    localparam logic [7:0] REV_OFF_BYTE = 8'h72;

    localparam int SEQ_MAX = 9;
    localparam int TEXT_W  = 8 * SEQ_MAX;

    typedef logic [TEXT_W-1:0] t_text;

    typedef enum logic [2:0] {
        SEQ_NONE     = 3'd0,
        SEQ_DRAW_ON  = 3'd1,
        SEQ_DRAW_OFF = 3'd2,
        SEQ_REV_ON   = 3'd3,
        SEQ_REV_OFF  = 3'd4,
        SEQ_COLOUR   = 3'd5
    } t_seq;

    typedef struct packed {
        t_seq       kind;
        logic [3:0] colour;
        logic       has_byte;
        logic [7:0] data;
    } t_cmd;

    localparam logic [255:0] GLYPH_TEXT = " lqkxmjlwktsuvmjABo`DEFGHIJKLMNO";

    localparam t_text COLOUR_TEXT [16] = '{
        t_text'("\033[0;30m"),   t_text'("\033[0;37;1m"),
        t_text'("\033[0;31m"),   t_text'("\033[0;36m"),
        t_text'("\033[0;35m"),   t_text'("\033[0;32m"),
        t_text'("\033[0;34m"),   t_text'("\033[0;33m"),
        t_text'("\033[0;33;2m"), t_text'("\033[0;31;2m"),
        t_text'("\033[0;31;1m"), t_text'("\033[0;31;2m"),
        t_text'("\033[0;31;2m"), t_text'("\033[0;32;1m"),
        t_text'("\033[0;34;1m"), t_text'("\033[0;37;2m")
    };

    localparam logic [3:0] COLOUR_LEN [16] = '{
        4'd7, 4'd9, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9
    };

    function automatic logic [7:0] glyph_byte(input logic [4:0] idx);
        logic [4:0] rev;
        rev = 5'd31 - idx;
        return GLYPH_TEXT[{rev, 3'b000} +: 8];
    endfunction

    function automatic t_text seq_text(input t_seq kind, input logic [3:0] colour);
        t_text s;
        unique case (kind)
            SEQ_DRAW_ON:  s = t_text'("\033(0");
            SEQ_DRAW_OFF: s = t_text'("\033(B");
            SEQ_REV_ON:   s = t_text'("\033[7m");
            SEQ_REV_OFF:  s = t_text'("\033[27m");
            SEQ_COLOUR:   s = COLOUR_TEXT[colour];
            default:      s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] seq_len(input t_seq kind, input logic [3:0] colour);
        logic [3:0] n;
        unique case (kind)
            SEQ_DRAW_ON:  n = 4'd3;
            SEQ_DRAW_OFF: n = 4'd3;
            SEQ_REV_ON:   n = 4'd4;
            SEQ_REV_OFF:  n = 4'd5;
            SEQ_COLOUR:   n = COLOUR_LEN[colour];
            default:      n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== src/vt100_char_translator.sv =====
// ----------------------------------------------------------------------------
// vt100_char_translator
// Turns character bytes into the VT100 byte stream that displays them.
// ----------------------------------------------------------------------------
// Input channel: present a byte on i_in_byte with push high; it transfers at
// a rising edge where full is low. Output channel: while empty is low the
// oldest result byte sits on o_out_byte with o_last marking the final byte
// of its input; it transfers at a rising edge where pop is high.
// An escape byte (27) only arms the colour prefix and gives no output.
// Each command is registered in the command queue, then its bytes in the output register.
// Throughput: the output side moves one byte per cycle while the receiver
// pops, and an input causes 1 byte for plain, 4 on a drawing-mode change,
// 4 or 5 for reverse video, 7 or 9 for colour sequences. The byte walker
// in the back end sets this pace; the front end takes one byte per
// cycle while the command queue (CMDQ_DEPTH entries) has room.
// Reset (i_rst_n low, synchronous) clears drawing mode, the colour prefix,
// the queue and the output register.
// When the receiver stalls the output byte holds, the queue fills, and full
// rises until bytes transfer again.
// ----------------------------------------------------------------------------
module vt100_char_translator
    import vtct_pkg::*;
#(
    parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    vtct_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_byte (i_in_byte),
        .i_q_full  (q_full),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_cmd     (front_cmd)
    );

    vtct_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (head_cmd),
        .o_empty (q_empty)
    );

    vtct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_head_empty (q_empty),
        .o_head_pop   (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

endmodule

// ===== src/vtct_front.sv =====
// ----------------------------------------------------------------------------
// vtct_front
// Input side: classify each byte, track drawing mode and colour prefix,
// and hand one command per non-escape input byte to the command queue.
// ----------------------------------------------------------------------------
module vtct_front
    import vtct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_in_byte,
    input  logic       i_q_full,
    output logic       o_full,
    output logic       o_q_push,
    output t_cmd       o_cmd
);

    logic r_line_draw, n_line_draw;
    logic r_colour_pending, n_colour_pending;
    logic accept;
    logic is_esc;
    logic is_plain;

    assign accept   = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign is_esc   = (i_in_byte == ESC_BYTE);
    assign is_plain = (i_in_byte[7:5] != 3'd0) || (i_in_byte == LF_BYTE)
                      || (i_in_byte == CR_BYTE);

    always_comb begin
        n_line_draw      = r_line_draw;
        n_colour_pending = r_colour_pending;
        o_cmd.kind       = SEQ_NONE;
        o_cmd.colour     = i_in_byte[3:0];
        o_cmd.has_byte   = 1'b1;
        o_cmd.data       = i_in_byte;
        if (is_esc) begin
            n_colour_pending = 1'b1;
        end else if (r_colour_pending) begin
            n_colour_pending = 1'b0;
            o_cmd.has_byte   = 1'b0;
            if (i_in_byte == REV_ON_BYTE) begin
                o_cmd.kind = SEQ_REV_ON;
            end else if (i_in_byte == REV_OFF_BYTE) begin
                o_cmd.kind = SEQ_REV_OFF;
            end else begin
                o_cmd.kind = SEQ_COLOUR;
            end
        end else if (is_plain) begin
            n_line_draw = 1'b0;
            if (r_line_draw) begin
                o_cmd.kind = SEQ_DRAW_OFF;
            end
        end else begin
            n_line_draw = 1'b1;
            o_cmd.data  = glyph_byte(i_in_byte[4:0]);
            if (!r_line_draw) begin
                o_cmd.kind = SEQ_DRAW_ON;
            end
        end
    end

    assign o_q_push = accept && !is_esc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_draw      <= 1'b0;
            r_colour_pending <= 1'b0;
        end else if (accept) begin
            r_line_draw      <= n_line_draw;
            r_colour_pending <= n_colour_pending;
        end
    end

endmodule

// ===== src/vtct_cmdq.sv =====
// ----------------------------------------------------------------------------
// vtct_cmdq
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module vtct_cmdq
    import vtct_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/vtct_back.sv =====
// ----------------------------------------------------------------------------
// vtct_back
// Output side: while the output register is free or popped, walk the escape
// text of the head command one byte per cycle, append any displayed byte, and hold each byte in the output register.
// ----------------------------------------------------------------------------
module vtct_back
    import vtct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_head_empty,
    output logic       o_head_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic [3:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    t_text      text;
    logic [3:0] len;
    logic [3:0] rem;
    t_text      shifted;
    logic       in_seq;
    logic       load;
    logic [7:0] emit_byte;
    logic       emit_last;

    assign text    = seq_text(i_head.kind, i_head.colour);
    assign len     = seq_len(i_head.kind, i_head.colour);
    assign in_seq  = (r_pos < len);
    assign rem     = len - 4'd1 - r_pos;
    assign shifted = text >> {rem, 3'b000};

    assign emit_byte = in_seq ? shifted[7:0] : i_head.data;
    assign emit_last = in_seq ? ((rem == 4'd0) && !i_head.has_byte) : 1'b1;

    assign load       = !i_head_empty && (!r_out_valid || i_pop);
    assign o_head_pop = load && emit_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_pos       <= emit_last ? 4'd0 : r_pos + 4'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

// ===== src/vtct_checker.sv =====
// ----------------------------------------------------------------------------
// vtct_checker
// Port-level checks of the VT100 character translator, bound to the top.
// ----------------------------------------------------------------------------
module vtct_checker
    import vtct_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] i_in_byte,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_last)))
        else $error("stalled result changed");

    a_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> !empty)
        else $error("sequence broken before its last byte");

    a_output_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && (i_in_byte != ESC_BYTE)) |-> ##2 !empty)
        else $error("no output two cycles after a displayed byte");

endmodule

bind vt100_char_translator vtct_checker u_vtct_checker (.*);

// ===== bench/vt100_char_translator_tb.sv =====
// ----------------------------------------------------------------------------
// vt100_char_translator_tb
// Self-checking bench for the VT100 character translator. A behavioral
// predictor tracks drawing mode and the colour prefix. It expands every
// transferred character into the terminal bytes it should produce. A monitor
// compares each popped byte and its last flag with the oldest predicted byte.
// Directed cases cover pass-through, line drawing and colour codes. Random
// character streams follow under changing idle patterns, with one long
// receiver stall that fills the block.
// ----------------------------------------------------------------------------
module vt100_char_translator_tb
    import vtct_pkg::*;
();

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_term_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic [7:0] i_in_byte = 8'd0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_last;

    t_term_byte term_q [$];
    logic       drawing_on = 1'b0;
    logic       colour_armed = 1'b0;
    int         send_gap_pct = 0;
    int         pop_gap_pct = 0;
    int         stall_requests = 0;
    int         stalls_served = 0;
    int         hold_left = 0;
    int         errors = 0;

    string glyph_map = " lqkxmjlwktsuvmjABo`DEFGHIJKLMNO";
    string colour_tail [16] = '{
        "30m",   "37;1m", "31m",   "36m",   "35m",   "32m",   "34m",   "33m",
        "33;2m", "31;2m", "31;1m", "31;2m", "31;2m", "32;1m", "34;1m", "37;2m"
    };

    vt100_char_translator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void expect_byte(input logic [7:0] b);
        t_term_byte tb;
        tb.data = b;
        tb.last = 1'b0;
        term_q.push_back(tb);
    endfunction

    function automatic void expect_escape(input string tail);
        expect_byte(ESC_BYTE);
        for (int i = 0; i < tail.len(); i++) begin
            expect_byte(tail[i]);
        end
    endfunction

    function automatic void predict_terminal_bytes(input logic [7:0] c);
        int         start;
        t_term_byte tb;
        start = term_q.size();
        if (c == ESC_BYTE) begin
            colour_armed = 1'b1;
        end else if (colour_armed) begin
            colour_armed = 1'b0;
            if (c == REV_ON_BYTE) begin
                expect_escape("[7m");
            end else if (c == REV_OFF_BYTE) begin
                expect_escape("[27m");
            end else begin
                expect_escape({"[0;", colour_tail[c[3:0]]});
            end
        end else if (c >= 8'd32 || c == LF_BYTE || c == CR_BYTE) begin
            if (drawing_on) begin
                expect_escape("(B");
                drawing_on = 1'b0;
            end
            expect_byte(c);
        end else begin
            if (!drawing_on) begin
                expect_escape("(0");
                drawing_on = 1'b1;
            end
            expect_byte(glyph_map[int'(c[4:0])]);
        end
        if (term_q.size() > start) begin
            tb = term_q.pop_back();
            tb.last = 1'b1;
            term_q.push_back(tb);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors = errors + 1;
    endtask

    // Monitor and receiver: check each transfer, then pick the next pop.
    always @(posedge i_clk) begin
        t_term_byte want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (term_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              o_out_byte, o_last));
                end else begin
                    want = term_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        report_mismatch($sformatf("byte %02h, want %02h",
                                                  o_out_byte, want.data));
                    end
                    if (o_last !== want.last) begin
                        report_mismatch($sformatf("last %0b, want %0b on byte %02h",
                                                  o_last, want.last, want.data));
                    end
                end
            end
            if (stall_requests != stalls_served) begin
                stalls_served = stalls_served + 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= pop_gap_pct);
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_byte <= c;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        predict_terminal_bytes(c);
    endtask

    task automatic test_passthrough();
        send_char(8'd32);
        send_char(8'd255);
        send_char(LF_BYTE);
        send_char(CR_BYTE);
        send_char(8'd128);
    endtask

    task automatic test_line_drawing();
        send_char(8'd0);
        send_char(8'd31);
        send_char(8'd9);
        send_char(8'd126);
        send_char(8'd11);
        send_char(8'd30);
        send_char(CR_BYTE);
        send_char(8'd12);
    endtask

    task automatic test_colour_codes();
        send_char(ESC_BYTE);
        send_char(REV_ON_BYTE);
        send_char(ESC_BYTE);
        send_char(REV_OFF_BYTE);
        // re-arm on a second escape, then highest colour index
        send_char(ESC_BYTE);
        send_char(ESC_BYTE);
        send_char(8'h1F);
        // colour byte taken while drawing mode stays on
        send_char(ESC_BYTE);
        send_char(8'h80);
        send_char(ESC_BYTE);
        send_char(LF_BYTE);
        send_char(8'd65);
    endtask

    task automatic test_random_stream(input int n);
        int kind;
        int pick;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                pick = $urandom_range(9);
                send_char(ESC_BYTE);
                if (pick == 0) begin
                    send_char(REV_ON_BYTE);
                end else if (pick == 1) begin
                    send_char(REV_OFF_BYTE);
                end else begin
                    send_char(8'($urandom_range(255)));
                end
            end else if (kind < 60) begin
                send_char(8'($urandom_range(31)));
            end else begin
                send_char(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_backpressure();
        stall_requests = stall_requests + 1;
        for (int i = 0; i < 16; i++) begin
            if (i % 4 == 0) begin
                send_char(ESC_BYTE);
            end
            send_char(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (term_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct = 36;
        pop_gap_pct = 62;
        test_passthrough();
        test_line_drawing();
        test_colour_codes();
        test_random_stream(20);

        send_gap_pct = 62;
        pop_gap_pct = 36;
        test_random_stream(20);

        send_gap_pct = 0;
        pop_gap_pct = 0;
        test_backpressure();
        test_random_stream(20);

        wait_for_drain();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/vtct_pkg.sv
src/vtct_front.sv
src/vtct_cmdq.sv
src/vtct_back.sv
src/vt100_char_translator.sv
src/vtct_checker.sv
bench/vt100_char_translator_tb.sv
